@@ hw/rtl/clt_pkg.sv @@
package clt_pkg;

    // scan modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_WORD   = 3'd1;
    localparam logic [2:0] MODE_STR    = 3'd2;
    localparam logic [2:0] MODE_ESC    = 3'd3;
    localparam logic [2:0] MODE_CLOSED = 3'd4;
    localparam logic [2:0] MODE_EOL    = 3'd5;
    localparam logic [2:0] MODE_ERR    = 3'd6;

    // result events
    localparam logic [2:0] EV_WCHAR = 3'd0;
    localparam logic [2:0] EV_SCHAR = 3'd1;
    localparam logic [2:0] EV_WEND  = 3'd2;
    localparam logic [2:0] EV_SEND  = 3'd3;
    localparam logic [2:0] EV_COMMA = 3'd4;
    localparam logic [2:0] EV_EOL   = 3'd5;
    localparam logic [2:0] EV_ERROR = 3'd6;

    // input kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_EOI     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] ch;
    } t_result;

    // one classified input item with one or two results
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_USCORE, CH_HYPHEN};
    endfunction

endpackage

@@ hw/rtl/command_line_tokenizer_top.sv @@
// channel   dir  width           contents
// s_*       in   tdata 8,tuser 2 one line byte, its kind (data, end of input, restart)
// m_*       out  tdata 8,tuser 3 token char or zero, event code, tlast on final result
//
// the front end classifies one input transfer per cycle while s_tready is high and updates the scan mode
// bytes with results go into a four-entry queue; s_tready drops only when it is full
// the back end drains one result per cycle while m_tready is high; a two-result byte leaves as two results
// an input transfer's first result is written into the queue and then into the output register
// synchronous active-low reset returns the scan mode to idle and empties queue and output
module command_line_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_value
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast
);
    import clt_pkg::*;

    logic               accept;
    logic               push;
    logic               pop;
    logic               full;
    logic               q_valid;
    t_entry             push_entry;
    t_entry             head_entry;
    logic [QCNT_W-1:0]  level;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    clt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (s_tuser),
        .i_byte   (s_tdata),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    clt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_full   (full),
        .o_valid  (q_valid),
        .o_entry  (head_entry),
        .o_level  (level)
    );

    clt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= QCNT_W'(QDEPTH))
        else $error("queue level above depth");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != EV_WCHAR && m_tuser != EV_SCHAR) |-> (m_tdata == 8'h00))
        else $error("nonzero char on marker event");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser <= EV_ERROR))
        else $error("event code out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

@@ hw/rtl/clt_front.sv @@
module clt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output clt_pkg::t_entry     o_entry
);
    import clt_pkg::*;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic       has_res;
    t_entry     ent;

    always_comb begin
        n_mode    = r_mode;
        has_res   = 1'b0;
        ent.two   = 1'b0;
        ent.r0    = '{ev: EV_ERROR, ch: 8'h00};
        ent.r1    = '{ev: EV_ERROR, ch: 8'h00};
        case (i_kind)
            KIND_DATA: begin
                case (r_mode)
                    MODE_IDLE: begin
                        if (i_byte == CH_NL) begin
                            n_mode = MODE_EOL; has_res = 1'b1; ent.r0.ev = EV_EOL;
                        end else if (is_space(i_byte)) begin
                            has_res = 1'b0;
                        end else if (i_byte == CH_QUOTE) begin
                            n_mode = MODE_STR;
                        end else if (i_byte == CH_COMMA) begin
                            has_res = 1'b1; ent.r0.ev = EV_COMMA;
                        end else if (is_word(i_byte)) begin
                            n_mode = MODE_WORD; has_res = 1'b1;
                            ent.r0 = '{ev: EV_WCHAR, ch: i_byte};
                        end else begin
                            n_mode = MODE_ERR; has_res = 1'b1;
                        end
                    end
                    MODE_WORD: begin
                        has_res = 1'b1;
                        if (is_word(i_byte)) begin
                            ent.r0 = '{ev: EV_WCHAR, ch: i_byte};
                        end else if (i_byte == CH_COMMA) begin
                            n_mode = MODE_IDLE; ent.two = 1'b1;
                            ent.r0.ev = EV_WEND; ent.r1.ev = EV_COMMA;
                        end else if (i_byte == CH_NL) begin
                            n_mode = MODE_EOL; ent.two = 1'b1;
                            ent.r0.ev = EV_WEND; ent.r1.ev = EV_EOL;
                        end else if (is_space(i_byte)) begin
                            n_mode = MODE_IDLE; ent.r0.ev = EV_WEND;
                        end else begin
                            n_mode = MODE_ERR;
                        end
                    end
                    MODE_STR: begin
                        if (i_byte == CH_BSLASH) begin
                            n_mode = MODE_ESC;
                        end else if (i_byte == CH_QUOTE) begin
                            n_mode = MODE_CLOSED;
                        end else if (i_byte == CH_NL) begin
                            n_mode = MODE_ERR; has_res = 1'b1;
                        end else begin
                            has_res = 1'b1; ent.r0 = '{ev: EV_SCHAR, ch: i_byte};
                        end
                    end
                    MODE_ESC: begin
                        has_res = 1'b1;
                        if (i_byte == CH_QUOTE) begin
                            n_mode = MODE_STR; ent.r0 = '{ev: EV_SCHAR, ch: CH_QUOTE};
                        end else if (i_byte == CH_NL) begin
                            n_mode = MODE_ERR;
                        end else if (i_byte == CH_BSLASH) begin
                            // backslash was literal, this one starts a new escape
                            n_mode = MODE_ESC; ent.r0 = '{ev: EV_SCHAR, ch: CH_BSLASH};
                        end else begin
                            n_mode = MODE_STR; ent.two = 1'b1;
                            ent.r0 = '{ev: EV_SCHAR, ch: CH_BSLASH};
                            ent.r1 = '{ev: EV_SCHAR, ch: i_byte};
                        end
                    end
                    MODE_CLOSED: begin
                        has_res = 1'b1;
                        if (i_byte == CH_COMMA) begin
                            n_mode = MODE_IDLE; ent.two = 1'b1;
                            ent.r0.ev = EV_SEND; ent.r1.ev = EV_COMMA;
                        end else if (i_byte == CH_NL) begin
                            n_mode = MODE_EOL; ent.two = 1'b1;
                            ent.r0.ev = EV_SEND; ent.r1.ev = EV_EOL;
                        end else if (is_space(i_byte)) begin
                            n_mode = MODE_IDLE; ent.r0.ev = EV_SEND;
                        end else begin
                            n_mode = MODE_ERR;
                        end
                    end
                    MODE_EOL: begin
                        has_res = 1'b1; ent.r0.ev = EV_EOL;
                    end
                    default: begin
                        n_mode = MODE_ERR; has_res = 1'b1;
                    end
                endcase
            end
            KIND_EOI: begin
                has_res = 1'b1;
                case (r_mode)
                    MODE_IDLE, MODE_EOL: begin
                        n_mode = MODE_EOL; ent.r0.ev = EV_EOL;
                    end
                    MODE_WORD: begin
                        n_mode = MODE_EOL; ent.two = 1'b1;
                        ent.r0.ev = EV_WEND; ent.r1.ev = EV_EOL;
                    end
                    MODE_CLOSED: begin
                        n_mode = MODE_EOL; ent.two = 1'b1;
                        ent.r0.ev = EV_SEND; ent.r1.ev = EV_EOL;
                    end
                    default: begin
                        n_mode = MODE_ERR;
                    end
                endcase
            end
            KIND_RESTART: begin
                n_mode = MODE_IDLE;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

    assign o_push  = i_accept && has_res;
    assign o_entry = ent;

endmodule

@@ hw/rtl/clt_queue.sv @@
module clt_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  clt_pkg::t_entry               i_entry,
    input  logic                          i_pop,
    output logic                          o_full,
    output logic                          o_valid,
    output clt_pkg::t_entry               o_entry,
    output logic [clt_pkg::QCNT_W-1:0]    o_level
);
    import clt_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign o_level = r_cnt;

endmodule

@@ hw/rtl/clt_back.sv @@
module clt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  clt_pkg::t_entry     i_entry,
    output logic                o_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import clt_pkg::*;

    logic    r_valid;
    logic    r_second;
    t_result r_res;
    logic    r_last;
    logic    load;
    logic    final_res;

    // output register is free or its transfer completes this cycle
    assign load      = !r_valid || m_tready;
    assign final_res = !(i_entry.two && !r_second);
    assign o_pop     = load && i_valid && final_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_second <= !final_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_res  <= r_second ? i_entry.r1 : i_entry.r0;
            r_last <= final_res;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = r_res.ch;
    assign m_tuser  = r_res.ev;
    assign m_tlast  = r_last;

endmodule
